// ===== rtl/core/luhn_card_brand_check_top_macros.svh =====
// Assertion macros shared by the Luhn card brand check RTL.
`ifndef LUHN_CARD_BRAND_CHECK_TOP_MACROS_SVH
`define LUHN_CARD_BRAND_CHECK_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LCBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LCBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lcbc_pkg.sv =====
// Types, constants and helper functions for the Luhn card brand check.
`timescale 1ns / 1ps

package lcbc_pkg;

    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned BRAND_W = 2;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
    localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
    localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

    // Brand codes reported on the result item.
    localparam logic [BRAND_W-1:0] BRAND_NONE      = 2'd0;
    localparam logic [BRAND_W-1:0] BRAND_PREFIX_3X = 2'd1;
    localparam logic [BRAND_W-1:0] BRAND_PREFIX_5X = 2'd2;
    localparam logic [BRAND_W-1:0] BRAND_PREFIX_4  = 2'd3;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [BRAND_W-1:0] t_brand;

    // Result item, packed highest field first.
    typedef struct packed {
        t_count digit_count;
        logic   luhn_ok;
        t_brand brand;
    } t_result;

    // Sum of two values below ten, modulo ten.
    function automatic t_digit add_mod10(input t_digit a, input t_digit b);
        logic [DIGIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 5'd10) begin
            s = s - 5'd10;
        end
        return s[DIGIT_W-1:0];
    endfunction

    // Luhn doubling of one digit: 2*d, minus nine when above nine.
    function automatic t_digit luhn_double(input t_digit d);
        logic [DIGIT_W:0] t;
        t = {d, 1'b0};
        if (t > 5'd9) begin
            t = t - 5'd9;
        end
        return t[DIGIT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/luhn_card_brand_check_top.sv =====
// Top level of the Luhn mod-10 card number check with brand classification.
`timescale 1ns / 1ps
`include "luhn_card_brand_check_top_macros.svh"

//  Channel   | Direction | Carries
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | one decimal digit per item, tlast on the final digit
//  m_axis    | out       | one result item per number: brand, Luhn flag, length
//
// An accepted digit sits in an input register, then the short
// modulo-ten update logic folds it into the running sums and, for the final
// digit, writes the result register. One digit is taken every cycle while
// the result side keeps up.
// Reset is synchronous and active low; it empties both registers and clears
// the running sums, count and prefix digits. A stalled result holds the input
// register only when that register carries a final digit; other digits keep
// flowing, since they give no result.

module luhn_card_brand_check_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] digit, [7:4] zero
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] brand, [2] luhn_ok, [7:3] digit_count
);

    import lcbc_pkg::*;

    // Input register.
    logic    r_in_valid;
    t_digit  r_in_digit;
    logic    r_in_last;

    // Running state of the number being received.
    t_digit  r_sum_even;
    t_digit  r_sum_odd;
    t_count  r_count;
    t_digit  r_first;
    t_digit  r_second;
    t_digit  n_sum_even;
    t_digit  n_sum_odd;
    t_count  n_count;
    t_digit  n_first;
    t_digit  n_second;

    // Result register.
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic    out_free;
    logic    advance;
    t_digit  dig;
    t_digit  dig_dbl;
    t_digit  sel_sum;
    logic    ok;

    assign out_free      = !r_out_valid || m_axis_tready;
    // A digit without the last flag gives no result and always moves on.
    assign advance       = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_comb begin
        // Digits above nine count as nine.
        dig      = (r_in_digit > DIGIT_MAX) ? DIGIT_MAX : r_in_digit;
        dig_dbl  = luhn_double(dig);

        n_first  = (r_count == t_count'(0)) ? dig : r_first;
        n_second = (r_count == t_count'(1)) ? dig : r_second;

        if (r_count[0]) begin
            n_sum_odd  = add_mod10(r_sum_odd, dig_dbl);
            n_sum_even = add_mod10(r_sum_even, dig);
        end else begin
            n_sum_even = add_mod10(r_sum_even, dig_dbl);
            n_sum_odd  = add_mod10(r_sum_odd, dig);
        end

        n_count = (r_count == COUNT_MAX) ? r_count : r_count + t_count'(1);

        // An even length doubles the even positions, an odd one the odd ones.
        sel_sum = n_count[0] ? n_sum_odd : n_sum_even;
        ok      = (sel_sum == t_digit'(0));

        n_out.digit_count = n_count;
        n_out.luhn_ok     = ok;
        priority if (n_count == LEN_15 && n_first == 4'd3 &&
                     (n_second == 4'd4 || n_second == 4'd7)) begin
            n_out.brand = BRAND_PREFIX_3X;
        end else if (n_count == LEN_16 && n_first == 4'd5 &&
                     n_second >= 4'd1 && n_second <= 4'd5) begin
            n_out.brand = BRAND_PREFIX_5X;
        end else if ((n_count == LEN_16 || n_count == LEN_13) && n_first == 4'd4) begin
            n_out.brand = BRAND_PREFIX_4;
        end else begin
            n_out.brand = BRAND_NONE;
        end
        if (!ok) begin
            n_out.brand = BRAND_NONE;
        end
    end

    // Input register: loads whenever it is empty or its item moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_digit <= s_axis_tdata[DIGIT_W-1:0];
            r_in_last  <= s_axis_tlast;
        end
    end

    // Running state: updated per digit, cleared after the final digit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_even <= '0;
            r_sum_odd  <= '0;
            r_count    <= '0;
            r_first    <= '0;
            r_second   <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_sum_even <= '0;
                r_sum_odd  <= '0;
                r_count    <= '0;
                r_first    <= '0;
                r_second   <= '0;
            end else begin
                r_sum_even <= n_sum_even;
                r_sum_odd  <= n_sum_odd;
                r_count    <= n_count;
                r_first    <= n_first;
                r_second   <= n_second;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out <= n_out;
        end
    end

    `LCBC_ASSERT_IMP(a_brand_needs_ok, i_clk, i_rst_n,
        r_out_valid && r_out.brand != BRAND_NONE, r_out.luhn_ok,
        "brand reported without a passing Luhn check")
    `LCBC_ASSERT_IMP(a_brand_length, i_clk, i_rst_n,
        r_out_valid && r_out.brand != BRAND_NONE,
        r_out.digit_count == LEN_13 || r_out.digit_count == LEN_15 ||
        r_out.digit_count == LEN_16,
        "brand reported for a length no brand allows")
    `LCBC_ASSERT_NXT(a_clear_after_last, i_clk, i_rst_n, advance && r_in_last,
        r_count == t_count'(0) && r_sum_even == t_digit'(0) && r_sum_odd == t_digit'(0),
        "state not cleared after the final digit")
    `LCBC_ASSERT_IMP(a_empty_sums_zero, i_clk, i_rst_n, r_count == t_count'(0),
        r_sum_even == t_digit'(0) && r_sum_odd == t_digit'(0),
        "running sums nonzero with no digits received")

endmodule
